// File: rtl/core/rde_pkg.sv
// Shared payload types and command codes for the reversible deque engine.
package rde_pkg;

  // Fixed payload widths
  localparam int CMD_W = 2;
  localparam int VAL_W = 8;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REVERSE = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_EMIT    = 2'd3
  } cmd_t;

  // Input item
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [VAL_W-1:0] value_res;
    logic             error;
    logic             empty_list;
    logic             last;
  } out_item_t;

endpackage

// File: rtl/core/rde_ring.sv
// Circular element store: wraps queue offsets onto slots, one write and one registered read.
module rde_ring #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 8
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] head,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_off,
  input  logic [VALUE_WIDTH-1:0]   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_off,
  output logic [VALUE_WIDTH-1:0]   rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]          wr_slot;
  logic [AW-1:0]          rd_slot;

  // head + offset modulo DEPTH; both terms are below DEPTH
  function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] h, input logic [AW-1:0] o);
    logic [AW:0] sum;
    sum = {1'b0, h} + {1'b0, o};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign wr_slot = wrap_slot(head, wr_off);
  assign rd_slot = wrap_slot(head, rd_off);

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_slot];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/reversible_deque_engine.sv
// Top level of the reversible deque engine: command decode, queue state and emit sequencer.
// Load, reverse and delete leave the engine idle, so the next command can be taken in the following cycle.
// Emit of an error or empty queue: a single result, valid in the cycle after the transfer, then idle.
// Emit of N elements: per element a read of the store, then a result that waits out any stall on the
// result side; commands are held off until the last transfer.
// Synchronous active-low reset empties the queue, clears direction and error; store is not cleared.
module reversible_deque_engine #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rde_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rde_pkg::out_item_t out_data
);

  import rde_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            rev_r, rev_nxt;
  logic            err_r, err_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            o_err_r, o_err_nxt;
  logic            o_emp_r, o_emp_nxt;
  logic            o_last_r, o_last_nxt;
  logic            o_elem_r, o_elem_nxt;

  logic                   in_xfer;
  logic                   out_xfer;
  cmd_t                   cmd;
  logic                   wr_en;
  logic                   rd_en;
  logic [AW-1:0]          rd_off;
  logic [CW-1:0]          rev_off;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   idx_is_last;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign cmd      = cmd_t'(in_data.cmd);
  assign wr_data  = VALUE_WIDTH'(in_data.value);

  // Read offset in current direction order
  assign rev_off     = count_r - CW'(1) - CW'(idx_r);
  assign rd_off      = rev_r ? rev_off[AW-1:0] : idx_r;
  assign idx_is_last = (CW'(idx_r) + CW'(1)) == count_r;

  assign wr_en = in_xfer && (cmd == CMD_LOAD) && !err_r && (count_r < CW'(DEPTH));
  assign rd_en = (state_r == S_RD);

  rde_ring #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ring (
    .clk     (clk),
    .head    (head_r),
    .wr_en   (wr_en),
    .wr_off  (count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_off  (rd_off),
    .rd_data (rd_data)
  );

  // Handshake and result payload
  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_data.value_res  = o_elem_r ? VAL_W'(rd_data) : '0;
  assign out_data.error      = o_err_r;
  assign out_data.empty_list = o_emp_r;
  assign out_data.last       = o_last_r;

  // Sequencer and queue state update
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    err_nxt    = err_r;
    idx_nxt    = idx_r;
    o_err_nxt  = o_err_r;
    o_emp_nxt  = o_emp_r;
    o_last_nxt = o_last_r;
    o_elem_nxt = o_elem_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (cmd == CMD_EMIT) begin
            idx_nxt    = '0;
            o_err_nxt  = err_r;
            o_emp_nxt  = !err_r && (count_r == '0);
            o_last_nxt = 1'b1;
            o_elem_nxt = 1'b0;
            if (err_r || (count_r == '0)) begin
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_RD;
            end
          end else if (!err_r) begin
            case (cmd)
              CMD_LOAD: begin
                if (count_r < CW'(DEPTH)) begin
                  count_nxt = count_r + CW'(1);
                end else begin
                  err_nxt = 1'b1;
                end
              end
              CMD_REVERSE: begin
                if (count_r != '0) begin
                  rev_nxt = !rev_r;
                end
              end
              CMD_DELETE: begin
                if (count_r == '0) begin
                  err_nxt = 1'b1;
                end else begin
                  count_nxt = count_r - CW'(1);
                  if (!rev_r) begin
                    head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_RD: begin
        // store read issued this cycle, data ready next
        o_err_nxt  = 1'b0;
        o_emp_nxt  = 1'b0;
        o_elem_nxt = 1'b1;
        o_last_nxt = idx_is_last;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_xfer) begin
          if (o_last_r) begin
            state_nxt = S_IDLE;
            head_nxt  = '0;
            count_nxt = '0;
            rev_nxt   = 1'b0;
            err_nxt   = 1'b0;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      err_r   <= err_nxt;
    end
  end

  // Emit index and result flags
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    o_err_r  <= o_err_nxt;
    o_emp_r  <= o_emp_nxt;
    o_last_r <= o_last_nxt;
    o_elem_r <= o_elem_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_data.last |=> !in_stall && count_r == '0 && !err_r && !rev_r)
    else $error("queue not cleared after final emit transfer");

  a_single_flag_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error || out_data.empty_list) |-> out_data.last
      && out_data.value_res == '0)
    else $error("error or empty item is not a lone final item");

  a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && cmd == CMD_EMIT |=> in_stall)
    else $error("input taken during emit");

endmodule

// File: tb/reversible_deque_engine_test.sv
// Self-checking testbench for the reversible deque engine: directed table, then random sequences.
module reversible_deque_engine_test;
  import rde_pkg::*;

  localparam int DEPTH        = 64;
  localparam int TOTAL_ITEMS  = 160;
  localparam int HANG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 20;

  // Canned result items for emits whose outcome is obvious
  localparam out_item_t NO_RES    = '0;
  localparam out_item_t EMPTY_RES = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam out_item_t ERROR_RES = '{8'h00, 1'b1, 1'b0, 1'b1};
  localparam out_item_t ZERO_RES  = '{8'h00, 1'b0, 1'b0, 1'b1};

  typedef struct {
    cmd_t      cmd;
    logic [7:0] value;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  // Directed stimulus; typed rows carry their single result, the rest use the mirror
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_EMIT,    8'h5A, 1'b1, EMPTY_RES},  // emit right after reset
    '{CMD_REVERSE, 8'hFF, 1'b0, NO_RES},     // reverse on empty: no effect
    '{CMD_DELETE,  8'h00, 1'b0, NO_RES},     // delete on empty: error
    '{CMD_LOAD,    8'hFF, 1'b0, NO_RES},     // dropped while error held
    '{CMD_EMIT,    8'h00, 1'b1, ERROR_RES},
    '{CMD_LOAD,    8'h00, 1'b0, NO_RES},     // zero value is a real element
    '{CMD_EMIT,    8'hFF, 1'b1, ZERO_RES},
    '{CMD_EMIT,    8'h00, 1'b1, EMPTY_RES},  // queue cleared by previous emit
    '{CMD_LOAD,    8'hFF, 1'b0, NO_RES},
    '{CMD_LOAD,    8'h01, 1'b0, NO_RES},
    '{CMD_LOAD,    8'h80, 1'b0, NO_RES},
    '{CMD_REVERSE, 8'h3C, 1'b0, NO_RES},
    '{CMD_DELETE,  8'hC3, 1'b0, NO_RES},     // reversed: removes the tail
    '{CMD_LOAD,    8'h7F, 1'b0, NO_RES},
    '{CMD_EMIT,    8'h00, 1'b0, NO_RES},     // reversed order stream
    '{CMD_LOAD,    8'h55, 1'b0, NO_RES},
    '{CMD_LOAD,    8'hAA, 1'b0, NO_RES},
    '{CMD_REVERSE, 8'h00, 1'b0, NO_RES},
    '{CMD_REVERSE, 8'hFF, 1'b0, NO_RES},
    '{CMD_DELETE,  8'hFF, 1'b0, NO_RES},     // forward: removes the head
    '{CMD_EMIT,    8'hFF, 1'b0, NO_RES},
    '{CMD_DELETE,  8'hC3, 1'b0, NO_RES},
    '{CMD_LOAD,    8'h12, 1'b0, NO_RES},
    '{CMD_REVERSE, 8'h34, 1'b0, NO_RES},
    '{CMD_EMIT,    8'h00, 1'b1, ERROR_RES}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Mirror of the queue state
  logic [7:0] mirror_store [DEPTH];
  logic [5:0] mirror_head;
  logic [6:0] mirror_count;
  bit         mirror_rev;
  bit         mirror_err;

  out_item_t emit_batch [$];
  out_item_t pending_results [$];
  out_item_t want;

  int idle_pct;
  int stall_pct;
  int sent_items;
  int failures;
  int idle_cycles;
  int seq_num;
  int roll;
  int len;

  reversible_deque_engine #(
    .DEPTH(DEPTH),
    .VALUE_WIDTH(8)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted command to the mirror; emit results land in emit_batch
  task automatic mirror_command(input in_item_t it);
    logic [6:0] off;
    logic [5:0] idx;
    out_item_t  res_item;
    emit_batch.delete();
    if (it.cmd == CMD_EMIT) begin
      if (mirror_err) begin
        emit_batch = {emit_batch, ERROR_RES};
      end else if (mirror_count == 0) begin
        emit_batch = {emit_batch, EMPTY_RES};
      end else begin
        for (int i = 0; i < mirror_count; i++) begin
          off = mirror_rev ? mirror_count - 7'd1 - 7'(i) : 7'(i);
          idx = mirror_head + off[5:0];
          res_item.value_res  = mirror_store[idx];
          res_item.error      = 1'b0;
          res_item.empty_list = 1'b0;
          res_item.last       = (i == mirror_count - 1);
          emit_batch = {emit_batch, res_item};
        end
      end
      mirror_head  = '0;
      mirror_count = '0;
      mirror_rev   = 1'b0;
      mirror_err   = 1'b0;
    end else if (!mirror_err) begin
      case (it.cmd)
        CMD_LOAD: begin
          if (mirror_count >= DEPTH) begin
            mirror_err = 1'b1;
          end else begin
            idx = mirror_head + mirror_count[5:0];
            mirror_store[idx] = it.value;
            mirror_count++;
          end
        end
        CMD_REVERSE: begin
          if (mirror_count != 0) mirror_rev = !mirror_rev;
        end
        default: begin
          if (mirror_count == 0) begin
            mirror_err = 1'b1;
          end else begin
            if (!mirror_rev) mirror_head++;
            mirror_count--;
          end
        end
      endcase
    end
  endtask

  // Drive one command until its transfer, then queue what it should produce
  task automatic send_item(input cmd_t c, input logic [7:0] v, input bit typed,
                           input out_item_t res);
    in_item_t it;
    it.cmd   = c;
    it.value = v;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror_command(it);
    if (typed) pending_results = {pending_results, res};
    else pending_results = {pending_results, emit_batch};
    sent_items++;
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value_res %0h error %0b empty_list %0b last %0b",
               out_data.value_res, out_data.error, out_data.empty_list, out_data.last);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value_res !== want.value_res) begin
          $error("value_res: expected %0h, got %0h", want.value_res, out_data.value_res);
          failures++;
        end
        if (out_data.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_data.error);
          failures++;
        end
        if (out_data.empty_list !== want.empty_list) begin
          $error("empty_list: expected %0b, got %0b", want.empty_list, out_data.empty_list);
          failures++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    mirror_head  = '0;
    mirror_count = '0;
    mirror_rev   = 1'b0;
    mirror_err   = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    sent_items   = 0;
    failures     = 0;
    idle_cycles  = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].cmd, dir_rows[r].value, dir_rows[r].typed, dir_rows[r].res);
    end

    // Random sequences, idling pattern rotating per sequence
    seq_num = 0;
    while (sent_items < TOTAL_ITEMS) begin
      case (seq_num % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      roll = $urandom_range(0, 99);
      if (seq_num == 2 || seq_num == 4) begin
        // Fill to capacity, then maybe overflow; a held error would block the fill
        if (mirror_err) send_item(CMD_EMIT, 8'($urandom), 1'b0, NO_RES);
        while (mirror_count < DEPTH) begin
          if ($urandom_range(0, 9) == 0) send_item(CMD_REVERSE, 8'($urandom), 1'b0, NO_RES);
          else send_item(CMD_LOAD, 8'($urandom), 1'b0, NO_RES);
        end
        len = (seq_num == 2) ? 0 : $urandom_range(1, 2);
        repeat (len) send_item(CMD_LOAD, 8'($urandom), 1'b0, NO_RES);
        case ($urandom_range(0, 2))
          0: send_item(CMD_REVERSE, 8'($urandom), 1'b0, NO_RES);
          1: send_item(CMD_DELETE, 8'($urandom), 1'b0, NO_RES);
          default: ;
        endcase
        send_item(CMD_EMIT, 8'($urandom), 1'b0, NO_RES);
      end else if (roll < 85) begin
        // Well-formed: mostly loads, deletes mainly while non-empty, closing emit
        len = $urandom_range(1, 12);
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (roll < 55) send_item(CMD_LOAD, 8'($urandom), 1'b0, NO_RES);
          else if (roll < 75) send_item(CMD_REVERSE, 8'($urandom), 1'b0, NO_RES);
          else if (mirror_count != 0 || roll >= 97)
            send_item(CMD_DELETE, 8'($urandom), 1'b0, NO_RES);
          else send_item(CMD_LOAD, 8'($urandom), 1'b0, NO_RES);
        end
        send_item(CMD_EMIT, 8'($urandom), 1'b0, NO_RES);
      end else begin
        // Noise: any command, any value
        len = $urandom_range(1, 6);
        repeat (len) send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, NO_RES);
      end
      seq_num++;
    end

    // Drain any leftover queue contents so nothing stays unchecked
    send_item(CMD_EMIT, 8'($urandom), 1'b0, NO_RES);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
